// ----- hw/rtl/atf_pkg.sv -----
// Shared types and constants for the address text formatter.
// Used by atf_scan, atf_char and address_text_formatter; no dependencies.
package atf_pkg;

   // Address family codes
   localparam logic [1:0] FAM_IPV4 = 2'd0;
   localparam logic [1:0] FAM_IPV6 = 2'd1;
   localparam logic [1:0] FAM_MAC  = 2'd2;
   localparam logic [1:0] FAM_NONE = 2'd3;

   // Text units: 0..7 hex groups or MAC octets, 8..11 dotted octets,
   // then the trailing colon of a zero run at the end, then the prefix.
   localparam int NUM_UNITS = 14;
   localparam int UNIT_W    = 4;
   localparam logic [UNIT_W-1:0] U_DOT0   = 4'd8;
   localparam logic [UNIT_W-1:0] U_TRAIL  = 4'd12;
   localparam logic [UNIT_W-1:0] U_PREFIX = 4'd13;

   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_LOW_A = 8'h61;

   typedef struct packed {
      logic [1:0]  family;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic        has_prefix;
      logic [7:0]  prefix_len;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
   } rsp_type;

   // Per-item layout found at accept time
   typedef struct packed {
      logic [NUM_UNITS-1:0] mask;
      logic                 run_ok;
      logic [2:0]           base;
   } info_type;

endpackage

// ----- hw/rtl/atf_scan.sv -----
// Layout scan: zero-run search for IPv6 and the set of text units to print.
// Depends on atf_pkg.
module atf_scan (
   input  atf_pkg::req_type  item,
   output atf_pkg::info_type info
);
   import atf_pkg::*;

   logic [15:0] grp [8];
   logic [7:0]  zero;
   logic [3:0]  run_len [8];
   logic [3:0]  best_len;
   logic [2:0]  best_base;
   logic        run_ok;
   logic        dotted;
   logic [3:0]  run_end;
   logic [NUM_UNITS-1:0] mask;

   // Split the address into groups and measure zero runs
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         grp[i]   = item.addr_hi[63-16*i -: 16];
         grp[i+4] = item.addr_lo[63-16*i -: 16];
      end
      for (int i = 0; i < 8; i++) begin
         zero[i] = (grp[i] == 16'h0000);
      end
      run_len[7] = {3'b000, zero[7]};
      for (int i = 6; i >= 0; i--) begin
         run_len[i] = zero[i] ? run_len[i+1] + 4'd1 : 4'd0;
      end
   end

   // Pick the first longest run
   always_comb begin
      best_len  = 4'd0;
      best_base = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (run_len[i] > best_len) begin
            best_len  = run_len[i];
            best_base = 3'(i);
         end
      end
      run_ok  = (best_len >= 4'd2);
      run_end = {1'b0, best_base} + best_len;
      dotted  = run_ok && (best_base == 3'd0) &&
                ((best_len == 4'd6) || ((best_len == 4'd5) && (grp[5] == 16'hffff)));
   end

   // Build the unit mask per family
   always_comb begin
      mask = '0;
      case (item.family)
         FAM_IPV4: begin
            mask[11:8] = 4'hf;
         end
         FAM_MAC: begin
            mask[5:0] = 6'h3f;
         end
         FAM_IPV6: begin
            for (int i = 0; i < 8; i++) begin
               mask[i] = !(run_ok && (4'(i) >= {1'b0, best_base}) && (4'(i) < run_end))
                         || (run_ok && (3'(i) == best_base));
            end
            if (dotted) begin
               mask[7:6]  = 2'b00;
               mask[11:8] = 4'hf;
            end
            mask[U_TRAIL] = run_ok && (run_end == 4'd8) && !dotted;
         end
         default: begin
            mask = '0;
         end
      endcase
      if (item.family != FAM_NONE) begin
         mask[U_PREFIX] = item.has_prefix;
      end
   end

   assign info.mask   = mask;
   assign info.run_ok = run_ok;
   assign info.base   = best_base;

endmodule

// ----- hw/rtl/atf_char.sv -----
// Character generator: text of one unit (separator plus digits) and the
// character at a position inside it. Depends on atf_pkg.
module atf_char (
   input  atf_pkg::req_type  item,
   input  atf_pkg::info_type info,
   input  logic [3:0]        unit,
   input  logic [2:0]        pos,
   output logic [7:0]        ch,
   output logic [2:0]        len
);
   import atf_pkg::*;

   logic [15:0] grp [8];
   logic [7:0]  oct [4];
   logic [7:0]  mac_oct [6];
   logic        is_hex;
   logic        sep_en;
   logic [7:0]  sep_ch;
   logic [15:0] hex_val;
   logic [7:0]  dec_val;
   logic [2:0]  nd;
   logic [2:0]  q;
   logic [1:0]  sh;
   logic [3:0]  nib;
   logic [1:0]  hund;
   logic [6:0]  rem_v;
   logic [3:0]  tens;
   logic [3:0]  ones;
   logic [1:0]  di;
   logic [3:0]  dec_dig;
   logic [7:0]  dig_ch;

   // Slice the address fields
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         grp[i]   = item.addr_hi[63-16*i -: 16];
         grp[i+4] = item.addr_lo[63-16*i -: 16];
         oct[i]   = item.addr_lo[31-8*i -: 8];
      end
      for (int i = 0; i < 6; i++) begin
         mac_oct[i] = item.addr_lo[47-8*i -: 8];
      end
   end

   // Describe the current unit
   always_comb begin
      is_hex  = 1'b1;
      sep_en  = 1'b0;
      sep_ch  = CH_COLON;
      hex_val = 16'h0000;
      dec_val = 8'h00;
      nd      = 3'd1;
      if (unit < U_DOT0) begin
         sep_en = (unit != 4'd0);
         if (item.family == FAM_MAC) begin
            hex_val = {8'h00, mac_oct[unit[2:0]]};
            nd      = 3'd2;
         end else begin
            hex_val = grp[unit[2:0]];
            if (hex_val[15:12] != 4'h0) nd = 3'd4;
            else if (hex_val[11:8] != 4'h0) nd = 3'd3;
            else if (hex_val[7:4] != 4'h0) nd = 3'd2;
            else nd = 3'd1;
            if (info.run_ok && (unit[2:0] == info.base)) begin
               sep_en = 1'b1;
               nd     = 3'd0;
            end
         end
      end else if (unit < U_TRAIL) begin
         is_hex  = 1'b0;
         dec_val = oct[unit[1:0]];
         sep_en  = (unit != U_DOT0) || (item.family == FAM_IPV6);
         sep_ch  = (unit == U_DOT0) ? CH_COLON : CH_DOT;
      end else if (unit == U_TRAIL) begin
         sep_en = 1'b1;
         nd     = 3'd0;
      end else begin
         is_hex  = 1'b0;
         dec_val = item.prefix_len;
         sep_en  = 1'b1;
         sep_ch  = CH_SLASH;
      end
      if (!is_hex) begin
         if (dec_val >= 8'd100) nd = 3'd3;
         else if (dec_val >= 8'd10) nd = 3'd2;
         else nd = 3'd1;
      end
   end

   // Decimal digits of a byte
   always_comb begin
      if (dec_val >= 8'd200) hund = 2'd2;
      else if (dec_val >= 8'd100) hund = 2'd1;
      else hund = 2'd0;
      rem_v = 7'(dec_val - ((hund == 2'd2) ? 8'd200 : (hund == 2'd1) ? 8'd100 : 8'd0));
      tens  = 4'(({8'h00, rem_v} * 15'd205) >> 11);
      ones  = 4'(rem_v - (7'(tens) * 7'd10));
   end

   // Select the character at pos
   always_comb begin
      q   = sep_en ? pos - 3'd1 : pos;
      sh  = nd[1:0] - 2'd1 - q[1:0];
      nib = 4'(hex_val >> {sh, 2'b00});
      di  = 2'(3'd3 - nd + q);
      case (di)
         2'd0:    dec_dig = {2'b00, hund};
         2'd1:    dec_dig = tens;
         default: dec_dig = ones;
      endcase
      if (is_hex) begin
         dig_ch = (nib < 4'd10) ? CH_ZERO + {4'h0, nib} : CH_LOW_A + {4'h0, nib} - 8'd10;
      end else begin
         dig_ch = CH_ZERO + {4'h0, dec_dig};
      end
      ch  = (sep_en && (pos == 3'd0)) ? sep_ch : dig_ch;
      len = nd + {2'b00, sep_en};
   end

endmodule

// ----- hw/rtl/address_text_formatter.sv -----
// Address text formatter, top level: input register, unit cursor, output register.
// Depends on atf_pkg, atf_scan and atf_char.
//
// Turns one IPv4, IPv6 or MAC address (with an optional /prefix) into its text,
// one ASCII character per rsp transfer, last set on the final one. An item
// yields one character per cycle while the output is not stalled; the single character
// path from the held item to the output register sets that rate. The next item
// is taken in the cycle its predecessor's last character moves to the output
// register, so characters flow with no gap. Family 3 items are taken and
// produce nothing.
module address_text_formatter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  atf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output atf_pkg::rsp_type rsp_data
);
   import atf_pkg::*;

   req_type              item_ff, item_in;
   info_type             info_ff, info_in;
   logic                 vld_ff, vld_in;
   logic [UNIT_W-1:0]    unit_ff, unit_in;
   logic [2:0]           pos_ff, pos_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_vld_ff, rsp_vld_in;

   info_type             scan_info;
   logic [7:0]           ch;
   logic [2:0]           len;
   logic [NUM_UNITS-1:0] later;
   logic [UNIT_W-1:0]    next_unit;
   logic [UNIT_W-1:0]    first_unit;
   logic                 out_free;
   logic                 emit;
   logic                 unit_done;
   logic                 item_last;
   logic                 take;

   atf_scan u_scan (
      .item (req_data),
      .info (scan_info)
   );

   atf_char u_char (
      .item (item_ff),
      .info (info_ff),
      .unit (unit_ff),
      .pos  (pos_ff),
      .ch   (ch),
      .len  (len)
   );

   // Find the first unit of a new item and the next unit after the cursor
   always_comb begin
      later      = info_ff.mask & ~((14'd2 << unit_ff) - 14'd1);
      next_unit  = '0;
      first_unit = '0;
      for (int i = NUM_UNITS - 1; i >= 0; i--) begin
         if (later[i]) next_unit = UNIT_W'(i);
         if (scan_info.mask[i]) first_unit = UNIT_W'(i);
      end
   end

   // Handshake
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign emit      = vld_ff && out_free;
   assign unit_done = (pos_ff == len - 3'd1);
   assign item_last = unit_done && (later == '0);
   assign req_stall = vld_ff && !(out_free && item_last);
   assign take      = req_valid && !req_stall;

   // Advance the cursor, load a new item
   always_comb begin
      item_in = item_ff;
      info_in = info_ff;
      vld_in  = vld_ff;
      unit_in = unit_ff;
      pos_in  = pos_ff;
      if (take) begin
         item_in = req_data;
         info_in = scan_info;
         vld_in  = (scan_info.mask != '0);
         unit_in = first_unit;
         pos_in  = 3'd0;
      end else if (emit) begin
         if (unit_done) begin
            unit_in = next_unit;
            pos_in  = 3'd0;
            if (item_last) vld_in = 1'b0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   // Fill the output register
   always_comb begin
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff;
      if (emit) begin
         rsp_in.out_char = ch;
         rsp_in.last     = item_last;
         rsp_vld_in      = 1'b1;
      end else if (out_free) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      item_ff <= item_in;
      info_ff <= info_in;
      unit_ff <= unit_in;
      pos_ff  <= pos_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
